// ===== hdl/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
`default_nettype none
package rhc_pkg;

  // Quotient width of both dividers, one bit resolved per stage
  localparam int unsigned QW = 16;
  // Divisor widths: saturation divides by an 8-bit sum, hue by 6*d
  localparam int unsigned SAT_DW = 8;
  localparam int unsigned HUE_DW = 11;
  // Front stage plus one stage per quotient bit
  localparam int unsigned LAT = QW + 1;

  // Word leaving the front stage
  typedef struct packed {
    logic              gray;
    logic [SAT_DW-1:0] sat_hi;
    logic [QW-1:0]     sat_lo;
    logic [SAT_DW-1:0] sat_den;
    logic [HUE_DW-1:0] hue_num;
    logic [HUE_DW-1:0] hue_den;
    logic [QW-1:0]     light;
  } front_t;

endpackage
`default_nettype wire

// ===== hdl/rhc_front.sv =====
// Front stage: max, min, lightness and divider operands, registered.
`default_nettype none
module rhc_front (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [7:0]     red_i,
  input  wire logic [7:0]     green_i,
  input  wire logic [7:0]     blue_i,
  output rhc_pkg::front_t     front_o
);
  import rhc_pkg::*;

  logic [7:0]        mx, mn, d;
  logic [8:0]        sum;
  logic [SAT_DW-1:0] den;
  logic [16:0]       light_x;
  logic [23:0]       sat_n;
  logic [HUE_DW-1:0] d6, d2, d4, numer;
  front_t            front_d, front_q;

  always_comb begin
    // extremes
    mx = (red_i > green_i) ? red_i : green_i;
    mx = (mx > blue_i) ? mx : blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    mn = (mn < blue_i) ? mn : blue_i;
    sum = {1'b0, mx} + {1'b0, mn};
    d   = mx - mn;
    // lightness = sum*65535/510 = sum*257/2
    light_x = {sum, 8'b0} + {8'b0, sum};
    // saturation divisor folds around mid grey
    den = (sum > 9'd255) ? SAT_DW'(9'd510 - sum) : sum[7:0];
    // d*65535 split into a high 8-bit part and a low 16-bit part
    sat_n = {d, 16'b0} - {16'b0, d};
    // hue numerator, modulo arithmetic; true value lies in 0..6d-1
    d2 = {2'b0, d, 1'b0};
    d4 = {1'b0, d, 2'b0};
    d6 = d2 + d4;
    if (mx == red_i) begin
      if (green_i < blue_i) numer = d6 + {3'b0, green_i} - {3'b0, blue_i};
      else                  numer = {3'b0, green_i} - {3'b0, blue_i};
    end else if (mx == green_i) begin
      numer = d2 + {3'b0, blue_i} - {3'b0, red_i};
    end else begin
      numer = d4 + {3'b0, red_i} - {3'b0, green_i};
    end
    front_d.gray    = (d == 8'd0);
    front_d.sat_hi  = sat_n[23:16];
    front_d.sat_lo  = sat_n[15:0];
    front_d.sat_den = den;
    front_d.hue_num = numer;
    front_d.hue_den = d6;
    front_d.light   = light_x[16:1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) front_q <= front_d;
  end

  assign front_o = front_q;

endmodule
`default_nettype wire

// ===== hdl/rhc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rhc_div #(
  parameter int unsigned DW = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [DW-1:0]         num_hi_i,
  input  wire logic [rhc_pkg::QW-1:0] num_lo_i,
  input  wire logic [DW-1:0]         den_i,
  output logic [rhc_pkg::QW-1:0]     quo_o
);
  import rhc_pkg::*;

  // num_hi_i is below den_i, so the quotient fits in QW bits
  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in, den_in, rem_d;
    logic [QW-1:0] lo_in, quo_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num_hi_i;
      assign den_in = den_i;
      assign lo_in  = num_lo_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // shift in next dividend bit, subtract if it fits
    always_comb begin
      trial = {rem_in, lo_in[QW-1]};
      ge    = (trial >= {1'b0, den_in});
      rem_d = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        lo_q[k]  <= {lo_in[QW-2:0], 1'b0};
        quo_q[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule
`default_nettype wire

// ===== hdl/rgb_to_hsl_convert.sv =====
// Top level of the RGB to HSL converter pipeline.
//
//  Channel | Direction | Handshake          | Word
//  input   | in        | valid_i / stall_o  | red_i, green_i, blue_i
//  output  | out       | valid_o / stall_i  | hue_o, saturation_o, lightness_o
//
// One pixel per cycle while the output is not stalled; one front stage, then 16
// divider stages (one quotient bit each) for saturation and hue in parallel.
// Reset clears the valid bits only; payload registers are not reset.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module rgb_to_hsl_convert (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [15:0]      hue_o,
  output logic [15:0]      saturation_o,
  output logic [15:0]      lightness_o
);
  import rhc_pkg::*;

  logic             en;
  logic [LAT-1:0]   vld_q;
  front_t           front;
  logic [QW-1:0]    sat_quo, hue_quo;
  logic             gray_q  [QW];
  logic [QW-1:0]    light_q [QW];

  // pipeline moves unless the result word is held
  assign en      = !(vld_q[LAT-1] && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  rhc_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .front_o (front)
  );

  rhc_div #(.DW(SAT_DW)) u_sat_div (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_hi_i (front.sat_hi),
    .num_lo_i (front.sat_lo),
    .den_i    (front.sat_den),
    .quo_o    (sat_quo)
  );

  rhc_div #(.DW(HUE_DW)) u_hue_div (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_hi_i (front.hue_num),
    .num_lo_i ('0),
    .den_i    (front.hue_den),
    .quo_o    (hue_quo)
  );

  // lightness and grey flag ride alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      gray_q[0]  <= front.gray;
      light_q[0] <= front.light;
      for (int k = 1; k < QW; k++) begin
        gray_q[k]  <= gray_q[k-1];
        light_q[k] <= light_q[k-1];
      end
    end
  end

  assign valid_o      = vld_q[LAT-1];
  assign hue_o        = gray_q[QW-1] ? '0 : hue_quo;
  assign saturation_o = gray_q[QW-1] ? '0 : sat_quo;
  assign lightness_o  = light_q[QW-1];

endmodule
`default_nettype wire

// ===== hdl/rhc_checker.sv =====
// Port-level checks for the RGB to HSL converter, bound to the top level.
`default_nettype none
module rhc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        stall_o,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [15:0] hue_o,
  input wire logic [15:0] saturation_o,
  input wire logic [15:0] lightness_o
);

  // input side only backs up when a result word is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without a held result");

  a_stall_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |-> stall_o)
    else $error("pipeline advanced over a held result");

  // held word stays valid, with hue and saturation stable
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(hue_o) && $stable(saturation_o)))
    else $error("held result changed");

  // zero saturation only for grey, which has zero hue
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturation_o == 16'd0) |-> (hue_o == 16'd0))
    else $error("grey word with non-zero hue");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && lightness_o == 16'd0) |-> (saturation_o == 16'd0))
    else $error("black word with non-zero saturation");

endmodule

bind rgb_to_hsl_convert rhc_checker u_rhc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .stall_o      (stall_o),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .lightness_o  (lightness_o)
);
`default_nettype wire
